// ----- sv/rmv_pkg.sv -----
// shared widths, limits and divider control types for the running mean and variance block
package rmv_pkg;

   localparam int SAMPLE_W = 32;
   localparam int CNT_W    = 32;
   localparam int SQ_W     = 63;
   localparam int PROD_W   = 2 * SAMPLE_W;
   localparam int NUM_W    = 64;
   localparam int DEN_W    = 32;
   localparam int STEP_W   = $clog2(NUM_W) + 1;

   localparam logic [CNT_W-1:0] CNT_MAX     = {CNT_W{1'b1}};
   localparam logic [SQ_W-1:0]  SQ_MAX      = {SQ_W{1'b1}};
   localparam logic [CNT_W-1:0] MIN_FOR_VAR = CNT_W'(2);

   // divider command: start a run, half selects a 32-bit dividend
   typedef struct packed {
      logic start;
      logic half;
   } div_cmd_type;

   // divider status: done pulses one cycle when the quotient is ready
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

// ----- sv/rmv_req_if.sv -----
// sample channel: valid, ready and one signed Q16.16 sample
interface rmv_req_if;
   import rmv_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

// ----- sv/rmv_rsp_if.sv -----
// result channel: valid, ready, count, mean and variance
interface rmv_rsp_if;
   import rmv_pkg::*;

   logic                       valid;
   logic                       ready;
   logic        [CNT_W-1:0]    sample_count;
   logic signed [SAMPLE_W-1:0] mean_value;
   logic        [SQ_W-1:0]     variance_value;

   modport source (output valid, output sample_count, output mean_value,
                   output variance_value, input ready);
   modport sink   (input valid, input sample_count, input mean_value,
                   input variance_value, output ready);
endinterface

// ----- sv/running_mean_variance.sv -----
// running mean and unbiased variance of a signed Q16.16 sample stream
//
//   channel   direction   beat contents
//   req_chan  in          sample (signed Q16.16)
//   rsp_chan  out         sample_count, mean_value (Q16.16), variance_value (unsigned Q31.32)
//
// the mean takes 32 divider steps and the variance 64 (only from the second
// sample on), plus setup, multiply and accumulate states, all on the single
// bit-per-cycle divider. req_chan.ready is high only while
// no sample is in work. a finished result waits in the output register, so
// the next sample may enter; it stalls at the end only if that register is
// still full. reset clears the count, mean and sum of squared deviations.
module running_mean_variance (
   input  logic            clock,
   input  logic            reset,
   rmv_req_if.sink         req_chan,
   rmv_rsp_if.source       rsp_chan
);
   import rmv_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE     = 8'b0000_0001,
      ST_DIV_MEAN = 8'b0000_0010,
      ST_RES      = 8'b0000_0100,
      ST_MUL      = 8'b0000_1000,
      ST_ACC      = 8'b0001_0000,
      ST_VSTART   = 8'b0010_0000,
      ST_VWAIT    = 8'b0100_0000,
      ST_DONE     = 8'b1000_0000
   } state_type;

   state_type                  state_ff, state_in;
   logic        [CNT_W-1:0]    cnt_ff, cnt_in;
   logic signed [SAMPLE_W-1:0] mean_ff, mean_in;
   logic        [SQ_W-1:0]     sq_ff, sq_in;
   logic signed [SAMPLE_W-1:0] x_ff, x_in;
   logic                       dneg_ff, dneg_in;
   logic        [SAMPLE_W-1:0] dmag_ff, dmag_in;
   logic        [SAMPLE_W-1:0] rmag_ff, rmag_in;
   logic        [PROD_W-1:0]   prod_ff, prod_in;
   logic        [SQ_W-1:0]     var_ff, var_in;
   logic                       rvalid_ff, rvalid_in;
   logic        [CNT_W-1:0]    rcnt_ff, rcnt_in;
   logic signed [SAMPLE_W-1:0] rmean_ff, rmean_in;
   logic        [SQ_W-1:0]     rvar_ff, rvar_in;

   div_cmd_type                div_cmd;
   div_stat_type               div_stat;
   logic        [NUM_W-1:0]    div_num;
   logic        [DEN_W-1:0]    div_den;
   logic        [NUM_W-1:0]    div_quo;

   logic                       req_acc;
   logic        [CNT_W-1:0]    cnt_next;
   logic        [SAMPLE_W:0]   d_full, d_abs;
   logic        [SAMPLE_W:0]   q_signed, nm_full;
   logic        [SAMPLE_W:0]   r_full, r_abs;
   logic        [SQ_W+1:0]     sum_full;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_acc        = req_chan.valid && req_chan.ready;

   // saturating count and deviation from the old mean
   assign cnt_next = (cnt_ff == CNT_MAX) ? cnt_ff : cnt_ff + CNT_W'(1);
   assign d_full   = {req_chan.sample[SAMPLE_W-1], req_chan.sample}
                   - {mean_ff[SAMPLE_W-1], mean_ff};
   assign d_abs    = d_full[SAMPLE_W] ? (~d_full + (SAMPLE_W+1)'(1)) : d_full;

   // new mean from the signed quotient
   assign q_signed = dneg_ff ? (~{1'b0, div_quo[SAMPLE_W-1:0]} + (SAMPLE_W+1)'(1))
                             : {1'b0, div_quo[SAMPLE_W-1:0]};
   assign nm_full  = {mean_ff[SAMPLE_W-1], mean_ff} + q_signed;

   // deviation from the new mean
   assign r_full = {x_ff[SAMPLE_W-1], x_ff} - {mean_ff[SAMPLE_W-1], mean_ff};
   assign r_abs  = r_full[SAMPLE_W] ? (~r_full + (SAMPLE_W+1)'(1)) : r_full;

   // saturating accumulate
   assign sum_full = {2'b00, sq_ff} + {1'b0, prod_ff};

   // divider operand select
   always_comb begin
      div_cmd.start = 1'b0;
      div_cmd.half  = 1'b1;
      div_num       = {{(NUM_W-SAMPLE_W){1'b0}}, d_abs[SAMPLE_W-1:0]};
      div_den       = cnt_next;
      if (state_ff == ST_IDLE) begin
         div_cmd.start = req_acc;
      end else if (state_ff == ST_VSTART) begin
         div_cmd.start = 1'b1;
         div_cmd.half  = 1'b0;
         div_num       = {{(NUM_W-SQ_W){1'b0}}, sq_ff};
         div_den       = cnt_ff - CNT_W'(1);
      end
   end

   rmv_div u_div (
      .clock    (clock),
      .reset    (reset),
      .cmd      (div_cmd),
      .dividend (div_num),
      .divisor  (div_den),
      .stat     (div_stat),
      .quotient (div_quo)
   );

   // sequencer
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      mean_in   = mean_ff;
      sq_in     = sq_ff;
      x_in      = x_ff;
      dneg_in   = dneg_ff;
      dmag_in   = dmag_ff;
      rmag_in   = rmag_ff;
      prod_in   = prod_ff;
      var_in    = var_ff;
      rvalid_in = rvalid_ff && !rsp_chan.ready;
      rcnt_in   = rcnt_ff;
      rmean_in  = rmean_ff;
      rvar_in   = rvar_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               cnt_in   = cnt_next;
               x_in     = req_chan.sample;
               dneg_in  = d_full[SAMPLE_W];
               dmag_in  = d_abs[SAMPLE_W-1:0];
               state_in = ST_DIV_MEAN;
            end
         end
         ST_DIV_MEAN: begin
            if (div_stat.done) begin
               mean_in  = nm_full[SAMPLE_W-1:0];
               state_in = ST_RES;
            end
         end
         ST_RES: begin
            rmag_in  = r_abs[SAMPLE_W-1:0];
            state_in = ST_MUL;
         end
         ST_MUL: begin
            prod_in  = dmag_ff * rmag_ff;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            sq_in = (sum_full > {2'b00, SQ_MAX}) ? SQ_MAX : sum_full[SQ_W-1:0];
            if (cnt_ff < MIN_FOR_VAR) begin
               var_in   = '0;
               state_in = ST_DONE;
            end else begin
               state_in = ST_VSTART;
            end
         end
         ST_VSTART: begin
            state_in = ST_VWAIT;
         end
         ST_VWAIT: begin
            if (div_stat.done) begin
               var_in   = div_quo[SQ_W-1:0];
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rvalid_ff || rsp_chan.ready) begin
               rvalid_in = 1'b1;
               rcnt_in   = cnt_ff;
               rmean_in  = mean_ff;
               rvar_in   = var_ff;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control and running state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         cnt_ff    <= '0;
         mean_ff   <= '0;
         sq_ff     <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         mean_ff   <= mean_in;
         sq_ff     <= sq_in;
         rvalid_ff <= rvalid_in;
      end
   end

   // working and output payload
   always_ff @(posedge clock) begin
      x_ff     <= x_in;
      dneg_ff  <= dneg_in;
      dmag_ff  <= dmag_in;
      rmag_ff  <= rmag_in;
      prod_ff  <= prod_in;
      var_ff   <= var_in;
      rcnt_ff  <= rcnt_in;
      rmean_ff <= rmean_in;
      rvar_ff  <= rvar_in;
   end

   assign rsp_chan.valid          = rvalid_ff;
   assign rsp_chan.sample_count   = rcnt_ff;
   assign rsp_chan.mean_value     = rmean_ff;
   assign rsp_chan.variance_value = rvar_ff;
endmodule

// ----- sv/rmv_div.sv -----
// shared restoring divider, one quotient bit per cycle, 32 or 64 bit dividend
module rmv_div (
   input  logic                       clock,
   input  logic                       reset,
   input  rmv_pkg::div_cmd_type       cmd,
   input  logic [rmv_pkg::NUM_W-1:0]  dividend,
   input  logic [rmv_pkg::DEN_W-1:0]  divisor,
   output rmv_pkg::div_stat_type      stat,
   output logic [rmv_pkg::NUM_W-1:0]  quotient
);
   import rmv_pkg::*;

   logic [NUM_W-1:0]  num_ff, num_in;
   logic [NUM_W-1:0]  quo_ff, quo_in;
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [STEP_W-1:0] steps_ff, steps_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   logic [DEN_W:0]    trial;
   logic [DEN_W:0]    diff;
   logic              ge;

   // one compare and subtract per step
   assign trial = {rem_ff, num_ff[NUM_W-1]};
   assign ge    = trial >= {1'b0, den_ff};
   assign diff  = trial - {1'b0, den_ff};

   always_comb begin
      num_in   = num_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      steps_in = steps_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (cmd.start) begin
         num_in   = cmd.half ? {dividend[NUM_W-DEN_W-1:0], {DEN_W{1'b0}}} : dividend;
         quo_in   = '0;
         rem_in   = '0;
         den_in   = divisor;
         steps_in = cmd.half ? STEP_W'(NUM_W - DEN_W) : STEP_W'(NUM_W);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         num_in   = {num_ff[NUM_W-2:0], 1'b0};
         quo_in   = {quo_ff[NUM_W-2:0], ge};
         rem_in   = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         steps_in = steps_ff - STEP_W'(1);
         if (steps_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         steps_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         steps_ff <= steps_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      num_ff <= num_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;
endmodule
